@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

    localparam int LFU_ENTRIES    = 16;
    localparam int LFU_COUNT_BITS = 16;
    localparam int LFU_CAP_W      = 5;
    localparam int LFU_DATA_W     = 32;
    localparam logic [LFU_CAP_W-1:0] LFU_CAP_RESET = LFU_CAP_W'(16);

    localparam logic LFU_OP_GET = 1'b0;
    localparam logic LFU_OP_PUT = 1'b1;

    localparam logic LFU_REG_CAPACITY = 1'b0;

    localparam logic [LFU_DATA_W-1:0] LFU_MISS_VALUE = '1;

    function automatic int lfu_idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int lfu_cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

@@ rtl/lfu_cell.sv @@
module lfu_cell import lfu_pkg::*; #(
    parameter int ENTRIES    = LFU_ENTRIES,
    parameter int COUNT_BITS = LFU_COUNT_BITS,
    parameter int CELL_IDX   = 0,
    parameter type t_scan    = logic,
    parameter type t_cmd     = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_apply,
    input  t_scan i_scan,
    output t_scan o_scan
);

    localparam int IDX_W = lfu_idx_w(ENTRIES);
    localparam int CNT_W = lfu_cnt_w(ENTRIES);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                   r_valid;
    logic [LFU_DATA_W-1:0]  r_key;
    logic [LFU_DATA_W-1:0]  r_data;
    logic [COUNT_BITS-1:0]  r_count;
    logic [IDX_W-1:0]       r_rank;
    t_scan                  r_scan;
    t_scan                  n_scan;

    logic w_hit;
    logic w_better;

    // scan step: fold this entry into the token from the left neighbor
    always_comb begin
        w_hit    = r_valid && (r_key == i_cmd.key);
        w_better = r_valid && (!i_scan.have_vic || (r_count < i_scan.vic_count) ||
                   ((r_count == i_scan.vic_count) && (r_rank > i_scan.vic_rank)));
        n_scan      = i_scan;
        n_scan.used = i_scan.used + CNT_W'(r_valid);
        if (w_hit) begin
            n_scan.found      = 1'b1;
            n_scan.found_idx  = MY_IDX;
            n_scan.found_rank = r_rank;
            n_scan.found_data = r_data;
        end
        if (!r_valid && !i_scan.have_free) begin
            n_scan.have_free = 1'b1;
            n_scan.free_idx  = MY_IDX;
        end
        if (w_better) begin
            n_scan.have_vic  = 1'b1;
            n_scan.vic_idx   = MY_IDX;
            n_scan.vic_count = r_count;
            n_scan.vic_rank  = r_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_apply) begin
            if (i_cmd.do_touch) begin
                if (i_cmd.touch_idx == MY_IDX) begin
                    r_rank <= '0;
                    if (r_count != '1) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                    if (i_cmd.do_write) begin
                        r_data <= i_cmd.data;
                    end
                end else if (r_valid && (r_rank < i_cmd.touch_rank)) begin
                    r_rank <= r_rank + IDX_W'(1);
                end
            end else if (i_cmd.do_insert) begin
                if (i_cmd.ins_idx == MY_IDX) begin
                    r_valid <= 1'b1;
                    r_key   <= i_cmd.key;
                    r_data  <= i_cmd.data;
                    r_count <= COUNT_BITS'(1);
                    r_rank  <= '0;
                end else if (r_valid) begin
                    if (i_cmd.do_evict && (i_cmd.vic_idx == MY_IDX)) begin
                        r_valid <= 1'b0;
                    end else if (!(i_cmd.do_evict && (r_rank > i_cmd.vic_rank))) begin
                        r_rank <= r_rank + IDX_W'(1);
                    end
                end
            end
        end
    end

endmodule

@@ rtl/lfu_cache_table_core.sv @@
// Steps: an accepted request goes through S_SCAN, then S_APPLY; o_done is registered
// from S_APPLY. A new request is taken only in S_IDLE; the search token walks the
// cell chain one cell per cycle, then S_APPLY updates all cells together.
// o_done marks each result for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, i_rst_n low) empties the table and sets capacity to 16.
module lfu_cache_table_core import lfu_pkg::*; #(
    parameter int ENTRIES    = LFU_ENTRIES,
    parameter int COUNT_BITS = LFU_COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic signed [LFU_DATA_W-1:0]  i_key,
    input  logic signed [LFU_DATA_W-1:0]  i_write_value,
    output logic                          o_done,
    output logic                          o_hit,
    output logic signed [LFU_DATA_W-1:0]  o_read_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W = lfu_idx_w(ENTRIES);
    localparam int CNT_W = lfu_cnt_w(ENTRIES);

    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       found_idx;
        logic [IDX_W-1:0]       found_rank;
        logic [LFU_DATA_W-1:0]  found_data;
        logic [CNT_W-1:0]       used;
        logic                   have_free;
        logic [IDX_W-1:0]       free_idx;
        logic                   have_vic;
        logic [IDX_W-1:0]       vic_idx;
        logic [COUNT_BITS-1:0]  vic_count;
        logic [IDX_W-1:0]       vic_rank;
    } t_scan;

    typedef struct packed {
        logic [LFU_DATA_W-1:0]  key;
        logic [LFU_DATA_W-1:0]  data;
        logic                   do_touch;
        logic                   do_write;
        logic [IDX_W-1:0]       touch_idx;
        logic [IDX_W-1:0]       touch_rank;
        logic                   do_insert;
        logic [IDX_W-1:0]       ins_idx;
        logic                   do_evict;
        logic [IDX_W-1:0]       vic_idx;
        logic [IDX_W-1:0]       vic_rank;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [IDX_W-1:0]       r_cnt;
    logic                   r_op;
    logic [LFU_DATA_W-1:0]  r_key;
    logic [LFU_DATA_W-1:0]  r_val;
    logic [LFU_CAP_W-1:0]   r_cap;
    logic                   r_done;
    logic                   r_hit;
    logic [LFU_DATA_W-1:0]  r_rdata;
    logic [LFU_DATA_W-1:0]  n_rdata;

    t_scan w_scan [ENTRIES+1];
    t_scan w_tok;
    t_cmd  w_cmd;
    logic  w_accept;
    logic  w_apply;
    logic  w_cfg_wr;
    logic  w_full;
    logic  w_put_miss;

    assign w_accept = start && !busy;
    assign w_apply  = (r_state == S_APPLY);
    assign busy     = (r_state != S_IDLE);
    assign w_tok    = w_scan[ENTRIES];
    assign w_scan[0] = '0;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == LFU_REG_CAPACITY) ? 32'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= LFU_CAP_RESET;
        end else if (w_cfg_wr && (paddr[2] == LFU_REG_CAPACITY)) begin
            r_cap <= pwdata[LFU_CAP_W-1:0];
        end
    end

    // request control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == IDX_W'(ENTRIES - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_apply;
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_val <= i_write_value;
        end
    end

    // decision from the finished token
    always_comb begin
        if (32'(r_cap) > 32'(ENTRIES)) begin
            w_full = 32'(w_tok.used) >= 32'(ENTRIES);
        end else begin
            w_full = 32'(w_tok.used) >= 32'(r_cap);
        end
        w_put_miss = (r_op == LFU_OP_PUT) && (r_cap != '0) && !w_tok.found;

        w_cmd            = '0;
        w_cmd.key        = r_key;
        w_cmd.data       = r_val;
        w_cmd.touch_idx  = w_tok.found_idx;
        w_cmd.touch_rank = w_tok.found_rank;
        w_cmd.vic_idx    = w_tok.vic_idx;
        w_cmd.vic_rank   = w_tok.vic_rank;
        w_cmd.ins_idx    = w_tok.free_idx;
        if (w_tok.found && ((r_op == LFU_OP_GET) || (r_cap != '0))) begin
            w_cmd.do_touch = 1'b1;
            w_cmd.do_write = (r_op == LFU_OP_PUT);
        end
        if (w_put_miss) begin
            w_cmd.do_evict = w_full && w_tok.have_vic;
            if (w_cmd.do_evict && (!w_tok.have_free || (w_tok.vic_idx < w_tok.free_idx))) begin
                w_cmd.ins_idx = w_tok.vic_idx;
            end
            w_cmd.do_insert = w_cmd.do_evict || w_tok.have_free;
        end

        if (r_op == LFU_OP_GET) begin
            n_rdata = w_tok.found ? w_tok.found_data : LFU_MISS_VALUE;
        end else begin
            n_rdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_hit   <= w_tok.found;
            r_rdata <= n_rdata;
        end
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_read_value = r_rdata;

    // cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .COUNT_BITS (COUNT_BITS),
            .CELL_IDX   (g),
            .t_scan     (t_scan),
            .t_cmd      (t_cmd)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_apply (w_apply),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1])
        );
    end

    a_done_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_APPLY))
        else $error("result without update cycle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result held longer than one cycle");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted request did not start a search");

    a_touch_xor_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply |-> !(w_cmd.do_touch && w_cmd.do_insert))
        else $error("touch and insert in one update");

    a_miss_inserts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && w_put_miss) |-> w_cmd.do_insert)
        else $error("put miss found no slot");

endmodule
